/* rtl/sequential_list_engine_assert.svh */
// ----------------------------------------------------------------------------
// sequential_list_engine assertion macros
// shared concurrent assertion forms for the list engine modules
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequential_list_engine: assertion failed");

// next-cycle implication, disabled during reset
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequential_list_engine: assertion failed");

`endif

/* rtl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// widths, codes and controller/datapath bundles of the sequential list engine
// ----------------------------------------------------------------------------
package sle_pkg;

    // list geometry
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int FUNC_W = 2;
    localparam int POS_W  = 8;
    localparam int KEY_W  = 31;
    localparam int PAY_W  = 64;
    localparam int STAT_W = 2;
    localparam int FPOS_W = 8;
    localparam int LCNT_W = 8;
    localparam int REC_W  = KEY_W + PAY_W;

    // width for position/count compares
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              setup;
        logic              step;
        logic              shift_wr;
        logic              ins_put;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              set_status;
        logic [STAT_W-1:0] status;
        logic              take_hit;
        logic              publish;
    } sle_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              ins_bad;
        logic              del_bad;
        logic              rem_zero;
        logic              pend;
        logic              hit;
        logic              out_busy;
    } sle_sts_t;

endpackage

/* rtl/sle_if.sv */
// ----------------------------------------------------------------------------
// sle channel interfaces
// valid/ready channels for list requests and list responses
// ----------------------------------------------------------------------------
interface sle_req_if;
    logic                      valid;
    logic                      ready;
    logic [sle_pkg::FUNC_W-1:0] func;
    logic [sle_pkg::POS_W-1:0]  position;
    logic [sle_pkg::KEY_W-1:0]  record_key;
    logic [sle_pkg::PAY_W-1:0]  record_payload;

    modport source (output valid, func, position, record_key, record_payload, input ready);
    modport sink   (input valid, func, position, record_key, record_payload, output ready);
endinterface

interface sle_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [sle_pkg::STAT_W-1:0] status;
    logic [sle_pkg::FPOS_W-1:0] found_position;
    logic [sle_pkg::PAY_W-1:0]  found_payload;
    logic [sle_pkg::LCNT_W-1:0] list_count;

    modport source (output valid, status, found_position, found_payload, list_count,
                    input ready);
    modport sink   (input valid, status, found_position, found_payload, list_count,
                    output ready);
endinterface

/* rtl/sle_ram.sv */
// ----------------------------------------------------------------------------
// sle_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/sle_datapath.sv */
// ----------------------------------------------------------------------------
// sle_datapath
// record store, walk counters, range checks and result registers
// ----------------------------------------------------------------------------
`include "sequential_list_engine_assert.svh"

module sle_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sle_pkg::sle_cmd_t          cmd,
    output sle_pkg::sle_sts_t          sts,
    input  logic [sle_pkg::FUNC_W-1:0] func,
    input  logic [sle_pkg::POS_W-1:0]  position,
    input  logic [sle_pkg::KEY_W-1:0]  record_key,
    input  logic [sle_pkg::PAY_W-1:0]  record_payload,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sle_pkg::STAT_W-1:0] status,
    output logic [sle_pkg::FPOS_W-1:0] found_position,
    output logic [sle_pkg::PAY_W-1:0]  found_payload,
    output logic [sle_pkg::LCNT_W-1:0] list_count
);
    import sle_pkg::*;

    // captured transaction
    logic [FUNC_W-1:0] func_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PAY_W-1:0]  pay_reg;

    // list and walk state
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  src_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] waddr_reg;
    logic [ADDR_W-1:0] lidx_reg;

    // working result
    logic [STAT_W-1:0] stat_reg;
    logic [FPOS_W-1:0] fpos_reg;
    logic [PAY_W-1:0]  fpay_reg;

    // output register
    logic              out_valid_reg;
    logic [STAT_W-1:0] ostat_reg;
    logic [FPOS_W-1:0] ofpos_reg;
    logic [PAY_W-1:0]  ofpay_reg;
    logic [LCNT_W-1:0] ocnt_reg;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CNT_W-1:0]  src_init;
    logic [CNT_W-1:0]  rem_init;
    logic              is_insert;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [REC_W-1:0]  ram_wr_data;
    logic [REC_W-1:0]  ram_rd_data;

    // range checks
    assign pos_ext   = CMP_W'(pos_reg);
    assign cnt_ext   = CMP_W'(count_reg);
    assign is_insert = (func_reg == FUNC_INSERT);

    assign sts.func     = func_reg;
    assign sts.full     = (count_reg == CNT_W'(CAPACITY));
    assign sts.ins_bad  = (pos_reg == '0) || (pos_ext > cnt_ext + CMP_W'(1));
    assign sts.del_bad  = (pos_reg == '0) || (pos_ext > cnt_ext);
    assign sts.rem_zero = (rem_reg == '0);
    assign sts.pend     = pend_reg;
    assign sts.hit      = pend_reg && (ram_rd_data[REC_W-1:PAY_W] == key_reg);
    assign sts.out_busy = out_valid_reg && !out_ready;

    // walk start point per operation
    always_comb
    begin
        case (func_reg)
            FUNC_INSERT:
            begin
                src_init = count_reg - CNT_W'(1);
                rem_init = CNT_W'(cnt_ext - pos_ext + CMP_W'(1));
            end
            FUNC_DELETE:
            begin
                src_init = CNT_W'(pos_ext);
                rem_init = CNT_W'(cnt_ext - pos_ext);
            end
            default:
            begin
                src_init = '0;
                rem_init = count_reg;
            end
        endcase
    end

    // store write select: shifted entry or new record
    always_comb
    begin
        ram_wr_en   = (cmd.shift_wr && pend_reg) || cmd.ins_put;
        ram_wr_addr = cmd.ins_put ? ADDR_W'(pos_reg - POS_W'(1)) : waddr_reg;
        ram_wr_data = cmd.ins_put ? {key_reg, pay_reg} : ram_rd_data;
    end

    sle_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.step),
        .rd_addr (src_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.step;
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            pos_reg  <= position;
            key_reg  <= record_key;
            pay_reg  <= record_payload;
            fpos_reg <= '0;
            fpay_reg <= '0;
        end
        if (cmd.setup)
        begin
            src_reg <= src_init;
            rem_reg <= rem_init;
        end
        else if (cmd.step)
        begin
            src_reg   <= is_insert ? src_reg - CNT_W'(1) : src_reg + CNT_W'(1);
            rem_reg   <= rem_reg - CNT_W'(1);
            waddr_reg <= is_insert ? src_reg[ADDR_W-1:0] + ADDR_W'(1)
                                   : src_reg[ADDR_W-1:0] - ADDR_W'(1);
            lidx_reg  <= src_reg[ADDR_W-1:0];
        end
        if (cmd.set_status)
        begin
            stat_reg <= cmd.status;
        end
        if (cmd.take_hit)
        begin
            stat_reg <= STAT_OK;
            fpos_reg <= FPOS_W'(CNT_W'(lidx_reg) + CNT_W'(1));
            fpay_reg <= ram_rd_data[PAY_W-1:0];
        end
        if (cmd.publish)
        begin
            ostat_reg <= stat_reg;
            ofpos_reg <= fpos_reg;
            ofpay_reg <= fpay_reg;
            ocnt_reg  <= LCNT_W'(count_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = ostat_reg;
    assign found_position = ofpos_reg;
    assign found_payload  = ofpay_reg;
    assign list_count     = ocnt_reg;

    // checks
    `SLE_ASSERT_IMPL(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SLE_ASSERT_IMPL(a_one_writer, clk, rst_n, cmd.ins_put, !(cmd.shift_wr && pend_reg))
    `SLE_ASSERT_IMPL(a_read_in_store, clk, rst_n, cmd.step, src_reg < CNT_W'(CAPACITY))

endmodule

/* rtl/sle_ctrl.sv */
// ----------------------------------------------------------------------------
// sle_ctrl
// operation sequencer: decode, shift walks, search walk and result hand-off
// ----------------------------------------------------------------------------
`include "sequential_list_engine_assert.svh"

module sle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sle_pkg::sle_sts_t sts,
    output sle_pkg::sle_cmd_t cmd
);
    import sle_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_MOVE,
        ST_INS_PUT,
        ST_DEL_MOVE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.set_status = 1'b1;
                unique case (sts.func)
                    FUNC_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.status = STAT_FULL;
                            state_next = ST_FINISH;
                        end
                        else if (sts.ins_bad)
                        begin
                            cmd.status = STAT_BAD_POS;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.status  = STAT_OK;
                            cmd.setup   = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            state_next  = ST_INS_MOVE;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (sts.del_bad)
                        begin
                            cmd.status = STAT_BAD_POS;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.status  = STAT_OK;
                            cmd.setup   = 1'b1;
                            cmd.cnt_dec = 1'b1;
                            state_next  = ST_DEL_MOVE;
                        end
                    end
                    FUNC_LOCATE:
                    begin
                        cmd.status = STAT_NOT_FOUND;
                        cmd.setup  = 1'b1;
                        state_next = ST_SEARCH;
                    end
                    default:
                    begin
                        cmd.status = STAT_OK;
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_INS_MOVE:
            begin
                // walk down from the tail, one entry up per cycle
                cmd.shift_wr = 1'b1;
                if (!sts.rem_zero)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT:
            begin
                cmd.ins_put = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_DEL_MOVE:
            begin
                // walk up from the hole, one entry down per cycle
                cmd.shift_wr = 1'b1;
                if (!sts.rem_zero)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SEARCH:
            begin
                if (sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (sts.rem_zero && !sts.pend)
                begin
                    state_next = ST_FINISH;
                end
                else if (!sts.rem_zero)
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    // checks
    `SLE_ASSERT_NEXT(a_hit_ends_search, clk, rst_n, (state_reg == ST_SEARCH) && sts.hit, state_reg == ST_FINISH)
    `SLE_ASSERT_NEXT(a_put_after_moves, clk, rst_n, (state_reg == ST_INS_MOVE) && sts.rem_zero, state_reg == ST_INS_PUT)
    `SLE_ASSERT_IMPL(a_publish_free, clk, rst_n, cmd.publish, !sts.out_busy)

endmodule

/* rtl/sequential_list_engine.sv */
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of up to CAPACITY records (31-bit key, 64-bit payload) with
// insert at a position, delete at a position and locate by key, one response
// per request. Requests are taken one at a time; a request is taken while the
// previous response still waits in the output register. An insert shifts the
// entries from the position to the tail up, a delete shifts the entries after
// it down, and a locate reads from the front until a match or the list end.
// The record store moves or reads one entry per cycle through its single read
// port and single write port. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sequential_list_engine (
    input logic       clk,
    input logic       rst_n,
    sle_req_if.sink   request,
    sle_rsp_if.source response
);
    import sle_pkg::*;

    sle_cmd_t cmd;
    sle_sts_t sts;

    // sequencer
    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // record store and result path
    sle_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (request.func),
        .position       (request.position),
        .record_key     (request.record_key),
        .record_payload (request.record_payload),
        .out_valid      (response.valid),
        .out_ready      (response.ready),
        .status         (response.status),
        .found_position (response.found_position),
        .found_payload  (response.found_payload),
        .list_count     (response.list_count)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for sequential_list_engine
// Drives insert, delete, locate and unused requests through the request
// channel and checks each response against a shadow copy of the list kept
// here. Covers empty-list and full-list refusals, bad positions, duplicate
// keys, random valid/ready idling, a long response stall and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
    import sle_pkg::*;

    // code the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int END_QUIET_CYCLES = CAPACITY + 12;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FPOS_W-1:0] found_position;
        logic [PAY_W-1:0]  found_payload;
        logic [LCNT_W-1:0] list_count;
    } list_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sle_req_if request_ch ();
    sle_rsp_if response_ch ();

    sequential_list_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    // shadow copy of the list
    logic [KEY_W-1:0] shadow_keys [CAPACITY];
    logic [PAY_W-1:0] shadow_payloads [CAPACITY];
    int               shadow_count = 0;

    list_outcome_t pending_outcomes [$];
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    bit            sender_no_idle = 1'b0;
    bit            receiver_no_idle = 1'b0;
    int            receiver_hold_cycles = 0;

    always #10 clk = ~clk;

    // apply one operation to the shadow list and return the expected response
    function automatic list_outcome_t apply_list_op(input logic [FUNC_W-1:0] op,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [PAY_W-1:0] payload);
        list_outcome_t outcome;
        int            p;
        outcome = '0;
        outcome.status = STAT_OK;
        p = pos;
        case (op)
            FUNC_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    outcome.status = STAT_FULL;
                else if (p < 1 || p > shadow_count + 1)
                    outcome.status = STAT_BAD_POS;
                else
                begin
                    for (int i = shadow_count; i >= p; i--)
                    begin
                        shadow_keys[i]     = shadow_keys[i-1];
                        shadow_payloads[i] = shadow_payloads[i-1];
                    end
                    shadow_keys[p-1]     = key;
                    shadow_payloads[p-1] = payload;
                    shadow_count++;
                end
            end
            FUNC_DELETE:
            begin
                if (p < 1 || p > shadow_count)
                    outcome.status = STAT_BAD_POS;
                else
                begin
                    for (int i = p - 1; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i]     = shadow_keys[i+1];
                        shadow_payloads[i] = shadow_payloads[i+1];
                    end
                    shadow_count--;
                end
            end
            FUNC_LOCATE:
            begin
                outcome.status = STAT_NOT_FOUND;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_keys[i] == key)
                    begin
                        outcome.status         = STAT_OK;
                        outcome.found_position = FPOS_W'(i + 1);
                        outcome.found_payload  = shadow_payloads[i];
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        outcome.list_count = LCNT_W'(shadow_count);
        return outcome;
    endfunction

    // offer one request, wait for its transaction, record the expected response
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] payload);
        int gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid          <= 1'b1;
        request_ch.func           <= op;
        request_ch.position       <= pos;
        request_ch.record_key     <= key;
        request_ch.record_payload <= payload;
        do
            @(posedge clk);
        while (!request_ch.ready);
        pending_outcomes.push_back(apply_list_op(op, pos, key, payload));
    endtask

    // sender pause until every response has come back
    task automatic drain_responses();
        request_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        // small pool gives duplicates and locate hits
        if ($urandom_range(0, 3) != 0)
            return KEY_W'($urandom_range(0, 15));
        return KEY_W'($urandom);
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        return {$urandom, $urandom};
    endfunction

    // refusals and the unused code on an empty list
    task automatic test_empty_list();
        send_request(FUNC_LOCATE, 8'd0, 31'd5, '0);
        send_request(FUNC_DELETE, 8'd1, 31'd0, '0);
        send_request(FUNC_DELETE, 8'd0, 31'd0, '0);
        send_request(FUNC_INSERT, 8'd0, 31'd1, 64'h1);
        send_request(FUNC_INSERT, 8'd2, 31'd1, 64'h2);
        send_request(FUNC_INSERT, 8'd255, 31'd1, 64'h3);
        send_request(FUNC_UNUSED, 8'd1, 31'd9, 64'h9);
    endtask

    // inserts at front, middle and end, locate hits and misses, deletes
    task automatic test_basic_edits();
        send_request(FUNC_INSERT, 8'd1, 31'd0, 64'h0);
        send_request(FUNC_INSERT, 8'd2, 31'h7fff_ffff, '1);
        send_request(FUNC_INSERT, 8'd1, 31'd100, 64'h0123_4567_89ab_cdef);
        send_request(FUNC_INSERT, 8'd2, 31'd200, 64'hdead_beef_0000_0001);
        send_request(FUNC_INSERT, 8'd5, 31'd200, 64'hdead_beef_0000_0002);
        send_request(FUNC_INSERT, 8'd7, 31'd300, 64'h5);
        send_request(FUNC_LOCATE, 8'd0, 31'd0, '0);
        send_request(FUNC_LOCATE, 8'd0, 31'h7fff_ffff, '0);
        send_request(FUNC_LOCATE, 8'd0, 31'd200, '0);
        send_request(FUNC_LOCATE, 8'd0, 31'd999, '0);
        send_request(FUNC_DELETE, 8'd6, 31'd0, '0);
        send_request(FUNC_DELETE, 8'd255, 31'd0, '0);
        send_request(FUNC_DELETE, 8'd5, 31'd0, '0);
        send_request(FUNC_DELETE, 8'd1, 31'd0, '0);
        send_request(FUNC_DELETE, 8'd2, 31'd0, '0);
        send_request(FUNC_UNUSED, 8'd255, 31'h7fff_ffff, '1);
    endtask

    // fill to capacity under a long response stall, then hit the full list
    task automatic test_fill_and_overflow();
        drain_responses();
        sender_no_idle       = 1'b1;
        receiver_hold_cycles = LONG_HOLD_CYCLES;
        while (shadow_count < CAPACITY)
            send_request(FUNC_INSERT, POS_W'($urandom_range(1, shadow_count + 1)),
                         pick_key(), pick_payload());
        sender_no_idle = 1'b0;
        // full check comes before the position check
        send_request(FUNC_INSERT, 8'd0, 31'd7, 64'h7);
        send_request(FUNC_INSERT, 8'd1, 31'd7, 64'h7);
        send_request(FUNC_INSERT, 8'd255, 31'd7, 64'h7);
        send_request(FUNC_LOCATE, 8'd0, shadow_keys[CAPACITY-1], '0);
        send_request(FUNC_DELETE, 8'(CAPACITY + 1), 31'd0, '0);
        send_request(FUNC_DELETE, 8'(CAPACITY), 31'd0, '0);
        send_request(FUNC_INSERT, 8'(CAPACITY), 31'h7fff_ffff, '1);
        send_request(FUNC_LOCATE, 8'd0, 31'h7fff_ffff, '0);
        send_request(FUNC_DELETE, 8'd1, 31'd0, '0);
    endtask

    // mostly valid edits with random content, some noise
    task automatic test_random_traffic(input int n_items);
        int               r;
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] key;
        for (int n = 0; n < n_items; n++)
        begin
            // stretch with no idling on either side
            sender_no_idle   = (n >= 100 && n < 140);
            receiver_no_idle = (n >= 100 && n < 140);
            r = $urandom_range(0, 99);
            if (r < 12)
                send_request(FUNC_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 255)),
                             KEY_W'($urandom), pick_payload());
            else if (r < 47)
            begin
                pos = POS_W'($urandom_range(1, (shadow_count < CAPACITY) ?
                                                shadow_count + 1 : CAPACITY));
                send_request(FUNC_INSERT, pos, pick_key(), pick_payload());
            end
            else if (r < 77)
            begin
                pos = (shadow_count > 0) ? POS_W'($urandom_range(1, shadow_count)) : 8'd1;
                send_request(FUNC_DELETE, pos, KEY_W'($urandom), pick_payload());
            end
            else
            begin
                if (shadow_count > 0 && $urandom_range(0, 3) != 0)
                    key = shadow_keys[$urandom_range(0, shadow_count - 1)];
                else
                    key = pick_key();
                send_request(FUNC_LOCATE, POS_W'($urandom_range(0, 255)), key, pick_payload());
            end
        end
        sender_no_idle   = 1'b0;
        receiver_no_idle = 1'b0;
    endtask

    // main sequence
    initial
    begin
        request_ch.valid          <= 1'b0;
        request_ch.func           <= '0;
        request_ch.position       <= '0;
        request_ch.record_key     <= '0;
        request_ch.record_payload <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_edits();
        test_fill_and_overflow();
        test_random_traffic(260);
        drain_responses();
        repeat (END_QUIET_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // response side: random stalls, plus a long hold on request
    initial
    begin
        int stall;
        response_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (receiver_hold_cycles > 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (receiver_hold_cycles) @(posedge clk);
                receiver_hold_cycles = 0;
            end
            stall = receiver_no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            response_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(response_ch.valid && response_ch.ready));
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // compare each response transaction with the oldest expectation
    always @(posedge clk)
    begin
        list_outcome_t want;
        if (rst_n && response_ch.valid && response_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("response transaction with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("status", want.status, response_ch.status);
                check_field("found_position", want.found_position,
                            response_ch.found_position);
                check_field("found_payload", want.found_payload, response_ch.found_payload);
                check_field("list_count", want.list_count, response_ch.list_count);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (response_ch.valid && response_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
